// File: rtl/core/kmcd_pkg.sv
// Package for the keypad matrix change detector.
// Holds shared types, register codes, widths and the scan code shift function.
// Used by kmcd_ctrl and keypad_matrix_change_detector; depends on nothing.
package kmcd_pkg;

    localparam int ROW_BITS   = 8;
    localparam int ROW_CNT_W  = 4;
    localparam int CODE_W     = 7;
    localparam int SCAN_W     = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 4;
    localparam int COL_IDX_W  = 3;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 16;

    localparam logic [3:0] ROW_COUNT_RST = 4'd8;
    localparam logic [3:0] COL_COUNT_RST = 4'd8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW_COUNT       = 3'd0,
        REG_COLUMN_COUNT    = 3'd1,
        REG_ROWS_ACTIVE_LOW = 3'd2,
        REG_FN_ENABLE       = 3'd3,
        REG_FN_ROW_POS      = 3'd4,
        REG_FN_COL_POS      = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic [3:0] row_count;
        logic [3:0] column_count;
        logic       rows_active_low;
        logic       fn_enable;
        logic [2:0] fn_row_pos;
        logic [2:0] fn_col_pos;
    } cfg_t;

    typedef struct packed {
        logic              key_valid;
        logic [SCAN_W-1:0] scan_code;
        logic              did_release;
        logic              release_layer;
        logic              did_press;
        logic              press_layer;
        logic              sync_mark;
    } res_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MERGE,
        ST_FN_RD,
        ST_FN_EVAL,
        ST_COL_RDF,
        ST_COL_RDP,
        ST_COL_CAP,
        ST_KEY,
        ST_LAYER,
        ST_FLUSH
    } state_t;

    // Smallest s with (1 << s) >= cols.
    function automatic logic [2:0] code_shift(input logic [3:0] cols);
        logic [2:0] s;
        if (cols <= 4'd1) begin
            s = 3'd0;
        end else if (cols <= 4'd2) begin
            s = 3'd1;
        end else if (cols <= 4'd4) begin
            s = 3'd2;
        end else if (cols <= 4'd8) begin
            s = 3'd3;
        end else begin
            s = 3'd4;
        end
        return s;
    endfunction

endpackage

// File: rtl/core/keypad_matrix_change_detector.sv
// Keypad matrix change detector: one request per sampled column; after the last
// column, one result per reported key. The sync mark rides on the last one, or
// on a result of its own when no key is reported. Each column is read and then
// merged. After the last column the Fn key is read, and each column is walked row
// by row, stalling while the output register is not drained. After reset the
// pressed-layer RAM is cleared with no request accepted.
module keypad_matrix_change_detector #(
    parameter int MAX_ROWS = 8,
    parameter int MAX_COLS = 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // column_index [2:0], row_bits [10:3], zero fill above.
    input  logic [kmcd_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    input  logic                             s_axis_tlast,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // scan_code [5:0], did_release [6], release_layer [7], did_press [8],
    // press_layer [9], zero fill above.
    output logic [kmcd_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    // key_valid [0].
    output logic                             m_axis_tuser,
    output logic                             m_axis_tlast,
    input  logic                             cfg_we,
    input  logic [kmcd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [kmcd_pkg::CFG_DATA_W-1:0]  cfg_data
);

    kmcd_pkg::cfg_t cfg_reg, cfg_next;
    kmcd_pkg::res_t out_reg, out_next;
    logic           out_valid_reg, out_valid_next;
    logic           out_free;
    logic           res_push;
    kmcd_pkg::res_t res;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (kmcd_pkg::cfg_reg_t'(cfg_index))
                kmcd_pkg::REG_ROW_COUNT:       cfg_next.row_count       = cfg_data;
                kmcd_pkg::REG_COLUMN_COUNT:    cfg_next.column_count    = cfg_data;
                kmcd_pkg::REG_ROWS_ACTIVE_LOW: cfg_next.rows_active_low = cfg_data[0];
                kmcd_pkg::REG_FN_ENABLE:       cfg_next.fn_enable       = cfg_data[0];
                kmcd_pkg::REG_FN_ROW_POS:      cfg_next.fn_row_pos      = cfg_data[2:0];
                kmcd_pkg::REG_FN_COL_POS:      cfg_next.fn_col_pos      = cfg_data[2:0];
                default:                       cfg_next                 = cfg_reg;
            endcase
        end
    end

    kmcd_ctrl #(
        .MAX_ROWS(MAX_ROWS),
        .MAX_COLS(MAX_COLS)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .in_valid(s_axis_tvalid),
        .in_ready(s_axis_tready),
        .in_col  (s_axis_tdata[kmcd_pkg::COL_IDX_W-1:0]),
        .in_rows (s_axis_tdata[kmcd_pkg::COL_IDX_W +: kmcd_pkg::ROW_BITS]),
        .in_last (s_axis_tlast),
        .out_free(out_free),
        .res_push(res_push),
        .res     (res)
    );

    assign out_free = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (res_push)
        begin
            out_next       = res;
            out_valid_next = 1'b1;
        end else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.row_count       <= kmcd_pkg::ROW_COUNT_RST;
            cfg_reg.column_count    <= kmcd_pkg::COL_COUNT_RST;
            cfg_reg.rows_active_low <= 1'b0;
            cfg_reg.fn_enable       <= 1'b0;
            cfg_reg.fn_row_pos      <= 3'd0;
            cfg_reg.fn_col_pos      <= 3'd0;
            out_valid_reg           <= 1'b0;
        end else
        begin
            cfg_reg       <= cfg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.key_valid;
    assign m_axis_tlast  = out_reg.sync_mark;
    assign m_axis_tdata  = {6'd0, out_reg.press_layer, out_reg.did_press,
                            out_reg.release_layer, out_reg.did_release, out_reg.scan_code};

    a_push_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> out_free)
        else $error("result pushed while output register is occupied");

    a_sync_only_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_reg.key_valid) |-> (out_reg.sync_mark && m_axis_tdata == '0))
        else $error("sync-only result carries key data or lacks sync mark");

    a_key_reports_event: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.key_valid) |-> (out_reg.did_release || out_reg.did_press))
        else $error("key result reports neither press nor release");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("request taken before the previous one was merged");

endmodule

// File: rtl/core/kmcd_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Standalone; used by kmcd_ctrl for the image and layer stores.
module kmcd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/kmcd_ctrl.sv
// Scan sequencer: merges column samples into the image RAM, then walks the keys
// against the previous image and the pressed-layer RAM. Uses kmcd_pkg, kmcd_ram.
module kmcd_ctrl #(
    parameter int MAX_ROWS = 8,
    parameter int MAX_COLS = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  kmcd_pkg::cfg_t                cfg,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [kmcd_pkg::COL_IDX_W-1:0] in_col,
    input  logic [kmcd_pkg::ROW_BITS-1:0] in_rows,
    input  logic                          in_last,
    input  logic                          out_free,
    output logic                          res_push,
    output kmcd_pkg::res_t                res
);

    localparam int ROW_LIM   = (MAX_ROWS < kmcd_pkg::ROW_BITS) ? MAX_ROWS : kmcd_pkg::ROW_BITS;
    localparam int COL_AW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int VLD_N     = 1 << COL_AW;
    localparam int CNT_W     = $clog2(MAX_COLS + 1);
    localparam int IMG_DEPTH = 2 << COL_AW;
    localparam int IMG_AW    = COL_AW + 1;
    localparam int SLOTS     = MAX_ROWS * 2 * MAX_COLS;
    localparam int SLOT_W    = $clog2(SLOTS);
    localparam int RW        = kmcd_pkg::ROW_BITS;
    localparam int RCW       = kmcd_pkg::ROW_CNT_W;

    kmcd_pkg::state_t state_reg, state_next;

    logic                           bank_reg, bank_next;
    logic [1:0][VLD_N-1:0]          vld_reg, vld_next;
    logic                           fn_held_reg, fn_held_next;
    logic                           fn_chg_reg, fn_chg_next;
    logic                           pend_valid_reg, pend_valid_next;
    logic [SLOT_W-1:0]              clr_reg, clr_next;
    logic [CNT_W-1:0]               c_reg, c_next;
    logic [RCW-1:0]                 r_reg, r_next;

    kmcd_pkg::res_t                 pend_reg, pend_next;
    logic [COL_AW-1:0]              col_reg, col_next;
    logic [RW-1:0]                  bits_reg, bits_next;
    logic                           inr_reg, inr_next;
    logic                           last_reg, last_next;
    logic [RW-1:0]                  fresh_w_reg, fresh_w_next;
    logic [RW-1:0]                  prev_w_reg, prev_w_next;
    logic                           key_is_reg, key_is_next;
    logic                           key_was_reg, key_was_next;
    logic [kmcd_pkg::CODE_W-1:0]    code_reg, code_next;

    logic                           img_we, img_re;
    logic [IMG_AW-1:0]              img_waddr, img_raddr;
    logic [RW-1:0]                  img_wdata, img_rdata;
    logic                           lay_we, lay_re;
    logic [SLOT_W-1:0]              lay_waddr, lay_raddr;
    logic                           lay_wdata, lay_rdata;

    logic [RCW-1:0]                 eff_rows;
    logic [CNT_W-1:0]               eff_cols;
    logic [2:0]                     shift;
    logic [RW-1:0]                  rmask;
    logic [RW-1:0]                  in_bits;
    logic                           in_range;
    logic                           rows_done;
    logic                           cols_done;
    logic                           cur_is, cur_was;
    logic                           skip_fn;
    logic                           key_hit;
    logic [kmcd_pkg::CODE_W-1:0]    cur_code;
    logic [COL_AW-1:0]              c_addr;
    logic [COL_AW-1:0]              fn_addr;
    logic                           fn_in;
    logic                           fn_now;
    kmcd_pkg::res_t                 new_res;

    kmcd_ram #(
        .WIDTH(RW),
        .DEPTH(IMG_DEPTH)
    ) u_img_ram (
        .clk  (clk),
        .we   (img_we),
        .waddr(img_waddr),
        .wdata(img_wdata),
        .re   (img_re),
        .raddr(img_raddr),
        .rdata(img_rdata)
    );

    kmcd_ram #(
        .WIDTH(1),
        .DEPTH(SLOTS)
    ) u_layer_ram (
        .clk  (clk),
        .we   (lay_we),
        .waddr(lay_waddr),
        .wdata(lay_wdata),
        .re   (lay_re),
        .raddr(lay_raddr),
        .rdata(lay_rdata)
    );

    // Geometry and key decode.
    always_comb
    begin
        eff_rows = (int'(cfg.row_count) > ROW_LIM) ? RCW'(ROW_LIM) : cfg.row_count;
        eff_cols = (int'(cfg.column_count) > MAX_COLS) ? CNT_W'(MAX_COLS)
                                                       : CNT_W'(cfg.column_count);
        shift = kmcd_pkg::code_shift(4'(eff_cols));
        for (int i = 0; i < RW; i++)
        begin
            rmask[i] = (RCW'(i) < eff_rows);
        end
        in_bits  = (cfg.rows_active_low ? ~in_rows : in_rows) & rmask;
        in_range = (int'(in_col) < int'(eff_cols));

        c_addr    = COL_AW'(c_reg);
        rows_done = (r_reg >= eff_rows);
        cols_done = (({1'b0, c_reg} + 1'b1) >= {1'b0, eff_cols});
        cur_is    = fresh_w_reg[r_reg[2:0]];
        cur_was   = prev_w_reg[r_reg[2:0]];
        skip_fn   = cfg.fn_enable && (r_reg == {1'b0, cfg.fn_row_pos})
                    && (8'(c_reg) == 8'(cfg.fn_col_pos));
        key_hit   = !skip_fn && ((cur_is != cur_was) || (fn_chg_reg && cur_is));
        cur_code  = ((kmcd_pkg::CODE_W)'(r_reg[2:0]) << shift)
                    + (kmcd_pkg::CODE_W)'(c_reg);

        fn_addr = COL_AW'(cfg.fn_col_pos);
        fn_in   = (int'(cfg.fn_col_pos) < MAX_COLS);
        fn_now  = fn_in && vld_reg[bank_reg][fn_addr] && img_rdata[cfg.fn_row_pos];

        new_res               = '0;
        new_res.key_valid     = 1'b1;
        new_res.scan_code     = code_reg[kmcd_pkg::SCAN_W-1:0];
        new_res.did_release   = key_was_reg;
        new_res.release_layer = key_was_reg && cfg.fn_enable && lay_rdata;
        new_res.did_press     = key_is_reg;
        new_res.press_layer   = key_is_reg && cfg.fn_enable && fn_held_reg;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            kmcd_pkg::ST_CLEAR:
            begin
                if (clr_reg == SLOT_W'(SLOTS - 1))
                begin
                    state_next = kmcd_pkg::ST_IDLE;
                end
            end
            kmcd_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = kmcd_pkg::ST_MERGE;
                end
            end
            kmcd_pkg::ST_MERGE:
            begin
                state_next = last_reg ? kmcd_pkg::ST_FN_RD : kmcd_pkg::ST_IDLE;
            end
            kmcd_pkg::ST_FN_RD:
            begin
                state_next = kmcd_pkg::ST_FN_EVAL;
            end
            kmcd_pkg::ST_FN_EVAL:
            begin
                state_next = (eff_cols == '0) ? kmcd_pkg::ST_FLUSH : kmcd_pkg::ST_COL_RDF;
            end
            kmcd_pkg::ST_COL_RDF:
            begin
                state_next = kmcd_pkg::ST_COL_RDP;
            end
            kmcd_pkg::ST_COL_RDP:
            begin
                state_next = kmcd_pkg::ST_COL_CAP;
            end
            kmcd_pkg::ST_COL_CAP:
            begin
                state_next = kmcd_pkg::ST_KEY;
            end
            kmcd_pkg::ST_KEY:
            begin
                if (rows_done)
                begin
                    state_next = cols_done ? kmcd_pkg::ST_FLUSH : kmcd_pkg::ST_COL_RDF;
                end else if (key_hit)
                begin
                    state_next = kmcd_pkg::ST_LAYER;
                end
            end
            kmcd_pkg::ST_LAYER:
            begin
                if (!pend_valid_reg || out_free)
                begin
                    state_next = kmcd_pkg::ST_KEY;
                end
            end
            kmcd_pkg::ST_FLUSH:
            begin
                if (out_free)
                begin
                    state_next = kmcd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = kmcd_pkg::ST_IDLE;
            end
        endcase
    end

    // Memory ports, results and register updates.
    always_comb
    begin
        in_ready        = (state_reg == kmcd_pkg::ST_IDLE);
        res_push        = 1'b0;
        res             = '0;
        img_we          = 1'b0;
        img_waddr       = '0;
        img_wdata       = '0;
        img_re          = 1'b0;
        img_raddr       = '0;
        lay_we          = 1'b0;
        lay_waddr       = '0;
        lay_wdata       = 1'b0;
        lay_re          = 1'b0;
        lay_raddr       = '0;
        bank_next       = bank_reg;
        vld_next        = vld_reg;
        fn_held_next    = fn_held_reg;
        fn_chg_next     = fn_chg_reg;
        pend_valid_next = pend_valid_reg;
        clr_next        = clr_reg;
        c_next          = c_reg;
        r_next          = r_reg;
        pend_next       = pend_reg;
        col_next        = col_reg;
        bits_next       = bits_reg;
        inr_next        = inr_reg;
        last_next       = last_reg;
        fresh_w_next    = fresh_w_reg;
        prev_w_next     = prev_w_reg;
        key_is_next     = key_is_reg;
        key_was_next    = key_was_reg;
        code_next       = code_reg;

        unique case (state_reg)
            kmcd_pkg::ST_CLEAR:
            begin
                lay_we    = 1'b1;
                lay_waddr = clr_reg;
                clr_next  = clr_reg + 1'b1;
            end
            kmcd_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    col_next  = COL_AW'(in_col);
                    bits_next = in_bits;
                    inr_next  = in_range;
                    last_next = in_last;
                    img_re    = 1'b1;
                    img_raddr = {bank_reg, COL_AW'(in_col)};
                end
            end
            kmcd_pkg::ST_MERGE:
            begin
                if (inr_reg)
                begin
                    img_we    = 1'b1;
                    img_waddr = {bank_reg, col_reg};
                    img_wdata = (vld_reg[bank_reg][col_reg] ? img_rdata : '0) | bits_reg;
                    vld_next[bank_reg][col_reg] = 1'b1;
                end
            end
            kmcd_pkg::ST_FN_RD:
            begin
                img_re    = 1'b1;
                img_raddr = {bank_reg, fn_addr};
            end
            kmcd_pkg::ST_FN_EVAL:
            begin
                if (cfg.fn_enable)
                begin
                    fn_chg_next  = (fn_now != fn_held_reg);
                    fn_held_next = fn_now;
                end else
                begin
                    fn_chg_next = 1'b0;
                end
                c_next = '0;
            end
            kmcd_pkg::ST_COL_RDF:
            begin
                img_re    = 1'b1;
                img_raddr = {bank_reg, c_addr};
            end
            kmcd_pkg::ST_COL_RDP:
            begin
                fresh_w_next = vld_reg[bank_reg][c_addr] ? img_rdata : '0;
                img_re       = 1'b1;
                img_raddr    = {~bank_reg, c_addr};
            end
            kmcd_pkg::ST_COL_CAP:
            begin
                prev_w_next = vld_reg[~bank_reg][c_addr] ? img_rdata : '0;
                r_next      = '0;
            end
            kmcd_pkg::ST_KEY:
            begin
                if (rows_done)
                begin
                    c_next = c_reg + 1'b1;
                end else if (key_hit)
                begin
                    lay_re       = 1'b1;
                    lay_raddr    = SLOT_W'(cur_code);
                    key_is_next  = cur_is;
                    key_was_next = cur_was;
                    code_next    = cur_code;
                end else
                begin
                    r_next = r_reg + 1'b1;
                end
            end
            kmcd_pkg::ST_LAYER:
            begin
                if (!pend_valid_reg || out_free)
                begin
                    if (pend_valid_reg)
                    begin
                        res_push = 1'b1;
                        res      = pend_reg;
                    end
                    pend_next       = new_res;
                    pend_valid_next = 1'b1;
                    if (key_is_reg)
                    begin
                        lay_we    = 1'b1;
                        lay_waddr = SLOT_W'(code_reg);
                        lay_wdata = new_res.press_layer;
                    end
                    r_next = r_reg + 1'b1;
                end
            end
            kmcd_pkg::ST_FLUSH:
            begin
                if (out_free)
                begin
                    res_push = 1'b1;
                    if (pend_valid_reg)
                    begin
                        res = pend_reg;
                    end
                    res.sync_mark       = 1'b1;
                    pend_valid_next     = 1'b0;
                    bank_next           = ~bank_reg;
                    vld_next[~bank_reg] = '0;
                end
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= kmcd_pkg::ST_CLEAR;
            bank_reg       <= 1'b0;
            vld_reg        <= '0;
            fn_held_reg    <= 1'b0;
            fn_chg_reg     <= 1'b0;
            pend_valid_reg <= 1'b0;
            clr_reg        <= '0;
            c_reg          <= '0;
            r_reg          <= '0;
        end else
        begin
            state_reg      <= state_next;
            bank_reg       <= bank_next;
            vld_reg        <= vld_next;
            fn_held_reg    <= fn_held_next;
            fn_chg_reg     <= fn_chg_next;
            pend_valid_reg <= pend_valid_next;
            clr_reg        <= clr_next;
            c_reg          <= c_next;
            r_reg          <= r_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg    <= pend_next;
        col_reg     <= col_next;
        bits_reg    <= bits_next;
        inr_reg     <= inr_next;
        last_reg    <= last_next;
        fresh_w_reg <= fresh_w_next;
        prev_w_reg  <= prev_w_next;
        key_is_reg  <= key_is_next;
        key_was_reg <= key_was_next;
        code_reg    <= code_next;
    end

endmodule
